>>> sv/fsoe_pkg.sv
// shared constants, types and width helpers for the face side-of-edge classifier
// no dependencies; every other file refers to this package by scoped names
package fsoe_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int NUM_VERTS         = 3;

  localparam int REG_INDEX_WIDTH = 3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_R_SQUARED = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_Z_SQUARED = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_Z_LINEAR  = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_CONSTANT  = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_LINE_SLOPE     = 3'd4;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_TOP_BOTTOM     = 3'd5;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_TOLERANCE      = 3'd6;

  localparam int TOLERANCE_RESET = 17;

  localparam int FACE_CLASS_WIDTH = 2;
  localparam logic [FACE_CLASS_WIDTH-1:0] FACE_OUTSIDE      = 2'd0;
  localparam logic [FACE_CLASS_WIDTH-1:0] FACE_INSIDE       = 2'd1;
  localparam logic [FACE_CLASS_WIDTH-1:0] FACE_UNDETERMINED = 2'd2;

  // position of a vertex against the line, tolerance band excluded
  typedef struct packed {
    logic above;
    logic below;
  } side_t;

  // width of the exact quadric value (scale 3F) with headroom for sign and sums
  function automatic int ev_width(input int w, input int f);
    int m;
    m = 3 * w;
    if (2 * w + f > m) m = 2 * w + f;
    if (w + 2 * f > m) m = w + 2 * f;
    return m + 3;
  endfunction

  // width of twice the distance to the line (scale 2F)
  function automatic int dist_width(input int w, input int f);
    int m;
    m = 2 * w;
    if (w + f + 1 > m) m = w + f + 1;
    return m + 2;
  endfunction

endpackage

>>> sv/fsoe_mult.sv
// first pipeline stage: per-vertex squares and coordinate products
// depends on fsoe_pkg
module fsoe_mult #(
  parameter int W = fsoe_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] r [fsoe_pkg::NUM_VERTS],
  input  logic signed [W-1:0] z [fsoe_pkg::NUM_VERTS],
  input  logic signed [W-1:0] line_slope,
  input  logic signed [W-1:0] coef_z_linear,
  output logic                valid,
  output logic signed [2*W-1:0] rr [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] zz [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] mr [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] cz [fsoe_pkg::NUM_VERTS],
  output logic signed [W-1:0]   z_q [fsoe_pkg::NUM_VERTS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      rr[k]  <= r[k] * r[k];
      zz[k]  <= z[k] * z[k];
      mr[k]  <= line_slope * r[k];
      cz[k]  <= coef_z_linear * z[k];
      z_q[k] <= z[k];
    end
  end

endmodule

>>> sv/fsoe_scale.sv
// second stage: coefficient times square, split in halves; cone distance to the line
// depends on fsoe_pkg
module fsoe_scale #(
  parameter int W = fsoe_pkg::COORD_WIDTH_DEF,
  parameter int F = fsoe_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [2*W-1:0] rr [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] zz [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] mr [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] cz [fsoe_pkg::NUM_VERTS],
  input  logic signed [W-1:0]   z  [fsoe_pkg::NUM_VERTS],
  input  logic signed [W-1:0]   coef_r_squared,
  input  logic signed [W-1:0]   coef_z_squared,
  input  logic signed [W-1:0]   coef_z_linear,
  output logic                  valid,
  output logic signed [2*W:0]   pr_lo [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] pr_hi [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W:0]   pz_lo [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] pz_hi [fsoe_pkg::NUM_VERTS],
  output logic signed [2*W-1:0] cz_q  [fsoe_pkg::NUM_VERTS],
  output logic signed [fsoe_pkg::dist_width(W, F)-1:0] d [fsoe_pkg::NUM_VERTS]
);

  localparam int DW = fsoe_pkg::dist_width(W, F);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      // low half taken as unsigned, high half carries the sign
      pr_lo[k] <= coef_r_squared * signed'({1'b0, rr[k][W-1:0]});
      pr_hi[k] <= coef_r_squared * signed'(rr[k][2*W-1:W]);
      pz_lo[k] <= coef_z_squared * signed'({1'b0, zz[k][W-1:0]});
      pz_hi[k] <= coef_z_squared * signed'(zz[k][2*W-1:W]);
      cz_q[k]  <= cz[k];
      // twice the height above z = m*r + c3/2
      d[k] <= (DW'(z[k]) <<< (F + 1)) - (DW'(mr[k]) <<< 1)
              - (DW'(coef_z_linear) <<< F);
    end
  end

endmodule

>>> sv/fsoe_sum.sv
// third and fourth stages: assemble the exact quadric value; cone side tests
// depends on fsoe_pkg
module fsoe_sum #(
  parameter int W = fsoe_pkg::COORD_WIDTH_DEF,
  parameter int F = fsoe_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [2*W:0]   pr_lo [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] pr_hi [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W:0]   pz_lo [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] pz_hi [fsoe_pkg::NUM_VERTS],
  input  logic signed [2*W-1:0] cz    [fsoe_pkg::NUM_VERTS],
  input  logic signed [fsoe_pkg::dist_width(W, F)-1:0] d [fsoe_pkg::NUM_VERTS],
  input  logic signed [W-1:0]   coef_constant,
  input  logic        [W-2:0]   tolerance,
  output logic                  valid,
  output logic signed [fsoe_pkg::ev_width(W, F)-1:0] ev [fsoe_pkg::NUM_VERTS],
  output fsoe_pkg::side_t       side [fsoe_pkg::NUM_VERTS]
);

  localparam int DW = fsoe_pkg::dist_width(W, F);
  localparam int EW = fsoe_pkg::ev_width(W, F);

  logic                  valid_c;
  logic signed [EW-1:0]  r_term [fsoe_pkg::NUM_VERTS];
  logic signed [EW-1:0]  z_term [fsoe_pkg::NUM_VERTS];
  logic signed [EW-1:0]  lin    [fsoe_pkg::NUM_VERTS];
  fsoe_pkg::side_t       side_c [fsoe_pkg::NUM_VERTS];
  logic signed [DW-1:0]  tol2;

  assign tol2 = DW'(signed'({1'b0, tolerance})) <<< (F + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
      valid   <= 1'b0;
    end else begin
      valid_c <= in_valid;
      valid   <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      r_term[k] <= (EW'(pr_hi[k]) <<< W) + EW'(pr_lo[k]);
      z_term[k] <= (EW'(pz_hi[k]) <<< W) + EW'(pz_lo[k]);
      lin[k]    <= (EW'(cz[k]) <<< F) + (EW'(coef_constant) <<< (2 * F));
      // exactly on the band edge counts as on the line
      side_c[k].above <= d[k] > tol2;
      side_c[k].below <= d[k] < -tol2;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      ev[k]   <= r_term[k] + z_term[k] + lin[k];
      side[k] <= side_c[k];
    end
  end

endmodule

>>> sv/fsoe_decide.sv
// last stage: tolerance tests on the quadric value and the face decision
// depends on fsoe_pkg
module fsoe_decide #(
  parameter int W = fsoe_pkg::COORD_WIDTH_DEF,
  parameter int F = fsoe_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [fsoe_pkg::ev_width(W, F)-1:0] ev [fsoe_pkg::NUM_VERTS],
  input  fsoe_pkg::side_t       side [fsoe_pkg::NUM_VERTS],
  input  logic                  cone_mode,
  input  logic                  top_bottom,
  input  logic        [W-2:0]   tolerance,
  output logic                  done,
  output logic [fsoe_pkg::FACE_CLASS_WIDTH-1:0] face_class
);

  localparam int EW = fsoe_pkg::ev_width(W, F);

  logic signed [EW-1:0] tol3;
  fsoe_pkg::side_t      q_side [fsoe_pkg::NUM_VERTS];
  fsoe_pkg::side_t      line_side;
  logic [fsoe_pkg::FACE_CLASS_WIDTH-1:0] cone_class;
  logic [fsoe_pkg::FACE_CLASS_WIDTH-1:0] quad_class;

  assign tol3 = EW'(signed'({1'b0, tolerance})) <<< (2 * F);

  always_comb begin
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      q_side[k].above = ev[k] > tol3;
      q_side[k].below = ev[k] < -tol3;
    end
  end

  // cone: the last vertex off the line wins
  always_comb begin
    line_side = '0;
    for (int k = 0; k < fsoe_pkg::NUM_VERTS; k++) begin
      if (side[k].above || side[k].below) line_side = side[k];
    end
    if (top_bottom ? line_side.below : line_side.above) cone_class = fsoe_pkg::FACE_OUTSIDE;
    else                                                cone_class = fsoe_pkg::FACE_INSIDE;
  end

  // quadric: the first vertex off the curve wins
  always_comb begin
    quad_class = fsoe_pkg::FACE_UNDETERMINED;
    for (int k = fsoe_pkg::NUM_VERTS - 1; k >= 0; k--) begin
      if (q_side[k].above)      quad_class = fsoe_pkg::FACE_OUTSIDE;
      else if (q_side[k].below) quad_class = fsoe_pkg::FACE_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    face_class <= cone_mode ? cone_class : quad_class;
  end

endmodule

>>> sv/face_side_of_edge_classify_top.sv
// face side-of-edge classifier, top level: register file and five-stage pipeline
// depends on fsoe_pkg, fsoe_mult, fsoe_scale, fsoe_sum, fsoe_decide
// a start transfer passes the mult, scale, sum and decide stages in order before the done strobe
// throughput: one face per cycle, set by the stage split of the vertex multipliers
// busy is high only during reset; no stall, each result shows for a single cycle
// synchronous reset clears the pipeline valids and loads register defaults
module face_side_of_edge_classify_top #(
  parameter int COORD_WIDTH   = fsoe_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = fsoe_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] v1_r,
  input  logic signed [COORD_WIDTH-1:0] v1_z,
  input  logic signed [COORD_WIDTH-1:0] v2_r,
  input  logic signed [COORD_WIDTH-1:0] v2_z,
  input  logic signed [COORD_WIDTH-1:0] v3_r,
  input  logic signed [COORD_WIDTH-1:0] v3_z,
  output logic                          done,
  output logic [fsoe_pkg::FACE_CLASS_WIDTH-1:0] face_class,
  input  logic                          wr_en,
  input  logic [fsoe_pkg::REG_INDEX_WIDTH-1:0] wr_index,
  input  logic [COORD_WIDTH-1:0]        wr_data
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NV = fsoe_pkg::NUM_VERTS;
  localparam int DW = fsoe_pkg::dist_width(W, F);
  localparam int EW = fsoe_pkg::ev_width(W, F);

  logic signed [W-1:0] coef_r_squared;
  logic signed [W-1:0] coef_z_squared;
  logic signed [W-1:0] coef_z_linear;
  logic signed [W-1:0] coef_constant;
  logic signed [W-1:0] line_slope;
  logic                top_bottom;
  logic [W-2:0]        tolerance;
  logic                cone_mode;
  logic                accept;

  logic signed [W-1:0] vr [NV];
  logic signed [W-1:0] vz [NV];

  logic                  a_valid;
  logic signed [2*W-1:0] a_rr [NV];
  logic signed [2*W-1:0] a_zz [NV];
  logic signed [2*W-1:0] a_mr [NV];
  logic signed [2*W-1:0] a_cz [NV];
  logic signed [W-1:0]   a_z  [NV];

  logic                  b_valid;
  logic signed [2*W:0]   b_pr_lo [NV];
  logic signed [2*W-1:0] b_pr_hi [NV];
  logic signed [2*W:0]   b_pz_lo [NV];
  logic signed [2*W-1:0] b_pz_hi [NV];
  logic signed [2*W-1:0] b_cz    [NV];
  logic signed [DW-1:0]  b_d     [NV];

  logic                  s_valid;
  logic signed [EW-1:0]  s_ev   [NV];
  fsoe_pkg::side_t       s_side [NV];

  assign busy   = rst;
  assign accept = start && !busy;

  assign vr[0] = v1_r;
  assign vz[0] = v1_z;
  assign vr[1] = v2_r;
  assign vz[1] = v2_z;
  assign vr[2] = v3_r;
  assign vz[2] = v3_z;

  // cone when the z-squared coefficient is exactly -1.0
  assign cone_mode = coef_z_squared == ({W{1'b1}} << F);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_r_squared <= '0;
      coef_z_squared <= {W{1'b1}} << F;
      coef_z_linear  <= '0;
      coef_constant  <= '0;
      line_slope     <= '0;
      top_bottom     <= 1'b1;
      tolerance      <= (W-1)'(fsoe_pkg::TOLERANCE_RESET);
    end else if (wr_en) begin
      unique case (wr_index)
        fsoe_pkg::REG_COEF_R_SQUARED: coef_r_squared <= wr_data;
        fsoe_pkg::REG_COEF_Z_SQUARED: coef_z_squared <= wr_data;
        fsoe_pkg::REG_COEF_Z_LINEAR:  coef_z_linear  <= wr_data;
        fsoe_pkg::REG_COEF_CONSTANT:  coef_constant  <= wr_data;
        fsoe_pkg::REG_LINE_SLOPE:     line_slope     <= wr_data;
        fsoe_pkg::REG_TOP_BOTTOM:     top_bottom     <= wr_data[0];
        fsoe_pkg::REG_TOLERANCE:      tolerance      <= wr_data[W-2:0];
        default: ;
      endcase
    end
  end

  fsoe_mult #(.W(W)) u_mult (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .r             (vr),
    .z             (vz),
    .line_slope    (line_slope),
    .coef_z_linear (coef_z_linear),
    .valid         (a_valid),
    .rr            (a_rr),
    .zz            (a_zz),
    .mr            (a_mr),
    .cz            (a_cz),
    .z_q           (a_z)
  );

  fsoe_scale #(.W(W), .F(F)) u_scale (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (a_valid),
    .rr             (a_rr),
    .zz             (a_zz),
    .mr             (a_mr),
    .cz             (a_cz),
    .z              (a_z),
    .coef_r_squared (coef_r_squared),
    .coef_z_squared (coef_z_squared),
    .coef_z_linear  (coef_z_linear),
    .valid          (b_valid),
    .pr_lo          (b_pr_lo),
    .pr_hi          (b_pr_hi),
    .pz_lo          (b_pz_lo),
    .pz_hi          (b_pz_hi),
    .cz_q           (b_cz),
    .d              (b_d)
  );

  fsoe_sum #(.W(W), .F(F)) u_sum (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (b_valid),
    .pr_lo         (b_pr_lo),
    .pr_hi         (b_pr_hi),
    .pz_lo         (b_pz_lo),
    .pz_hi         (b_pz_hi),
    .cz            (b_cz),
    .d             (b_d),
    .coef_constant (coef_constant),
    .tolerance     (tolerance),
    .valid         (s_valid),
    .ev            (s_ev),
    .side          (s_side)
  );

  fsoe_decide #(.W(W), .F(F)) u_decide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_valid),
    .ev         (s_ev),
    .side       (s_side),
    .cone_mode  (cone_mode),
    .top_bottom (top_bottom),
    .tolerance  (tolerance),
    .done       (done),
    .face_class (face_class)
  );

  // every start transfer comes out as a done strobe, and nothing else does
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted face did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without a matching start transfer");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (face_class == fsoe_pkg::FACE_OUTSIDE || face_class == fsoe_pkg::FACE_INSIDE
              || face_class == fsoe_pkg::FACE_UNDETERMINED))
    else $error("face class out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule
